// File: hdl/wcc_pkg.sv
`timescale 1ns / 1ps

package wcc_pkg;

  localparam int PIX_W      = 8;
  localparam int SAMPLE_W   = 8;
  localparam int SHIFT_W    = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  // input register, multiply, subtract/range check, four radix-4 divide steps
  localparam int NUM_STAGES = 7;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_BLUE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_GREEN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RED = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_BLUE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_GREEN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_RED = 3'd5;

  localparam logic [SAMPLE_W-1:0] SAMPLE_BLUE_RST = 8'd170;
  localparam logic [SAMPLE_W-1:0] SAMPLE_GREEN_RST = 8'd160;
  localparam logic [SAMPLE_W-1:0] SAMPLE_RED_RST = 8'd170;
  localparam logic signed [SHIFT_W-1:0] SHIFT_BLUE_RST = 9'sd150;
  localparam logic signed [SHIFT_W-1:0] SHIFT_GREEN_RST = 9'sd120;
  localparam logic signed [SHIFT_W-1:0] SHIFT_RED_RST = -9'sd50;

  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
  } wcc_ctrl_t;

endpackage

// File: hdl/wcc_chan.sv
`timescale 1ns / 1ps

module wcc_chan (
  input  logic                                     clk,
  input  wcc_pkg::wcc_ctrl_t                       ctrl,
  input  logic [wcc_pkg::PIX_W-1:0]                pix,
  input  logic [wcc_pkg::SAMPLE_W-1:0]             sample,
  input  logic signed [wcc_pkg::SHIFT_W-1:0]       shift,
  output logic [wcc_pkg::PIX_W-1:0]                result
);

  // stage 0
  logic [7:0]        s_lim;
  logic              below;
  logic [7:0]        p0;
  logic [7:0]        d0;
  logic [7:0]        w0;
  logic signed [8:0] c0;

  // stage 1
  logic [15:0]        pd1;
  logic signed [17:0] cw1;
  logic [7:0]         d1;

  // stage 2 and divide steps: index 0 is the subtract stage
  logic signed [17:0] num;
  logic [16:0]        rem_q [0:4];
  logic [7:0]         quo_q [0:4];
  logic [7:0]         d_q   [0:4];
  logic               neg_q [0:4];
  logic               ovf_q [0:4];
  logic [16:0]        rem_next [1:4];
  logic [7:0]         quo_next [1:4];

  always_comb begin
    if (sample == 8'd0) begin
      s_lim = 8'd1;
    end else if (sample == 8'd255) begin
      s_lim = 8'd254;
    end else begin
      s_lim = sample;
    end
    below = pix < s_lim;
  end

  // weight numerator d - t reduces to p below the sample and 255 - p above it
  always_ff @(posedge clk) begin
    if (ctrl.load[0]) begin
      p0 <= pix;
      d0 <= below ? s_lim : 8'd255 - s_lim;
      w0 <= below ? pix : 8'd255 - pix;
      c0 <= shift;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[1]) begin
      pd1 <= 16'(p0) * 16'(d0);
      cw1 <= 18'(c0) * $signed({10'b0, w0});
      d1  <= d0;
    end
  end

  assign num = $signed({2'b00, pd1}) - cw1;

  // negative numerator truncates to a value at or below zero: clamp to zero
  always_ff @(posedge clk) begin
    if (ctrl.load[2]) begin
      rem_q[0] <= num[16:0];
      quo_q[0] <= 8'd0;
      d_q[0]   <= d1;
      neg_q[0] <= num[17];
      ovf_q[0] <= !num[17] && (num[16:0] >= {1'b0, d1, 8'b0});
    end
  end

  // restoring division, two quotient bits per stage
  always_comb begin
    logic [16:0] dh;
    logic [16:0] dl;
    logic [16:0] rm;
    logic        b1;
    logic        b0;
    int          hi;
    for (int j = 1; j <= 4; j++) begin
      hi = 9 - 2 * j;
      dh = 17'(d_q[j-1]) << hi;
      b1 = rem_q[j-1] >= dh;
      rm = b1 ? rem_q[j-1] - dh : rem_q[j-1];
      dl = 17'(d_q[j-1]) << (hi - 1);
      b0 = rm >= dl;
      rem_next[j] = b0 ? rm - dl : rm;
      quo_next[j] = quo_q[j-1];
      quo_next[j][3'(hi)] = b1;
      quo_next[j][3'(hi - 1)] = b0;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 1; j <= 4; j++) begin
      if (ctrl.load[2+j]) begin
        rem_q[j] <= rem_next[j];
        quo_q[j] <= quo_next[j];
        d_q[j]   <= d_q[j-1];
        neg_q[j] <= neg_q[j-1];
        ovf_q[j] <= ovf_q[j-1];
      end
    end
  end

  always_comb begin
    if (neg_q[4]) begin
      result = 8'd0;
    end else if (ovf_q[4]) begin
      result = 8'd255;
    end else begin
      result = quo_q[4];
    end
  end

endmodule

// File: hdl/weighted_color_correction.sv
`timescale 1ns / 1ps

// Weighted color correction of blue-green-red pixels. Each 8-bit channel has a
// white sample and a signed shift; the shift is removed in full at the sample
// and with a weight falling linearly to zero toward 0 or 255, and the result
// is truncated toward zero and clamped to 0..255. The datapath is a 7-stage
// pipeline (input register, multiply, subtract and range check, four radix-4
// divide steps), sustaining one pixel per clock while out_ready is high. Each
// stage holds its pixel while the next stage cannot take it, so bubbles are
// squeezed out when the output stalls. Configuration writes take effect at
// once and must be made with no pixel in flight.
module weighted_color_correction (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [wcc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [wcc_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [wcc_pkg::PIX_W-1:0]             pix_blue,
  input  logic [wcc_pkg::PIX_W-1:0]             pix_green,
  input  logic [wcc_pkg::PIX_W-1:0]             pix_red,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [wcc_pkg::PIX_W-1:0]             out_blue,
  output logic [wcc_pkg::PIX_W-1:0]             out_green,
  output logic [wcc_pkg::PIX_W-1:0]             out_red
);

  localparam int LAST = wcc_pkg::NUM_STAGES - 1;

  logic [wcc_pkg::SAMPLE_W-1:0]       sample_blue;
  logic [wcc_pkg::SAMPLE_W-1:0]       sample_green;
  logic [wcc_pkg::SAMPLE_W-1:0]       sample_red;
  logic signed [wcc_pkg::SHIFT_W-1:0] shift_blue;
  logic signed [wcc_pkg::SHIFT_W-1:0] shift_green;
  logic signed [wcc_pkg::SHIFT_W-1:0] shift_red;

  logic [wcc_pkg::NUM_STAGES-1:0] valid;
  logic [wcc_pkg::NUM_STAGES-1:0] valid_in;
  logic [wcc_pkg::NUM_STAGES-1:0] stage_ready;
  wcc_pkg::wcc_ctrl_t             ctrl;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_blue  <= wcc_pkg::SAMPLE_BLUE_RST;
      sample_green <= wcc_pkg::SAMPLE_GREEN_RST;
      sample_red   <= wcc_pkg::SAMPLE_RED_RST;
      shift_blue   <= wcc_pkg::SHIFT_BLUE_RST;
      shift_green  <= wcc_pkg::SHIFT_GREEN_RST;
      shift_red    <= wcc_pkg::SHIFT_RED_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        wcc_pkg::REG_SAMPLE_BLUE:  sample_blue  <= cfg_data[7:0];
        wcc_pkg::REG_SAMPLE_GREEN: sample_green <= cfg_data[7:0];
        wcc_pkg::REG_SAMPLE_RED:   sample_red   <= cfg_data[7:0];
        wcc_pkg::REG_SHIFT_BLUE:   shift_blue   <= $signed(cfg_data);
        wcc_pkg::REG_SHIFT_GREEN:  shift_green  <= $signed(cfg_data);
        wcc_pkg::REG_SHIFT_RED:    shift_red    <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // a stage takes a request when it is empty or its own request moves on
  always_comb begin
    valid_in[0] = in_valid;
    for (int k = 1; k < wcc_pkg::NUM_STAGES; k++) begin
      valid_in[k] = valid[k-1];
    end
    stage_ready[LAST] = !valid[LAST] || out_ready;
    for (int k = LAST - 1; k >= 0; k--) begin
      stage_ready[k] = !valid[k] || stage_ready[k+1];
    end
    ctrl.load = stage_ready & valid_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      for (int k = 0; k < wcc_pkg::NUM_STAGES; k++) begin
        if (stage_ready[k]) begin
          valid[k] <= valid_in[k];
        end
      end
    end
  end

  assign in_ready  = stage_ready[0];
  assign out_valid = valid[LAST];

  wcc_chan u_blue (
    .clk    (clk),
    .ctrl   (ctrl),
    .pix    (pix_blue),
    .sample (sample_blue),
    .shift  (shift_blue),
    .result (out_blue)
  );

  wcc_chan u_green (
    .clk    (clk),
    .ctrl   (ctrl),
    .pix    (pix_green),
    .sample (sample_green),
    .shift  (shift_green),
    .result (out_green)
  );

  wcc_chan u_red (
    .clk    (clk),
    .ctrl   (ctrl),
    .pix    (pix_red),
    .sample (sample_red),
    .shift  (shift_red),
    .result (out_red)
  );

endmodule

// File: hdl/wcc_checker.sv
`timescale 1ns / 1ps

module wcc_sva (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  cfg_write,
  input logic [wcc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input logic [wcc_pkg::CFG_DATA_W-1:0]        cfg_data,
  input logic                                  in_valid,
  input logic                                  in_ready,
  input logic [wcc_pkg::PIX_W-1:0]             pix_blue,
  input logic [wcc_pkg::PIX_W-1:0]             pix_green,
  input logic [wcc_pkg::PIX_W-1:0]             pix_red,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic [wcc_pkg::PIX_W-1:0]             out_blue,
  input logic [wcc_pkg::PIX_W-1:0]             out_green,
  input logic [wcc_pkg::PIX_W-1:0]             out_red
);

  // hold a stalled result
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("stalled result dropped");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_blue) && $stable(out_green) && $stable(out_red))
    else $error("stalled result changed");

  // reset empties the pipeline
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown after reset");

  // a draining output never backs up the input
  assert property (@(posedge clk) out_ready |-> in_ready)
    else $error("input stalled while output drains");

endmodule

bind weighted_color_correction wcc_sva u_checker (.*);

// File: verif/wcc_checker.sv
`timescale 1ns / 1ps

module wcc_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [wcc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wcc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [wcc_pkg::PIX_W-1:0]      pix_blue,
  input  logic [wcc_pkg::PIX_W-1:0]      pix_green,
  input  logic [wcc_pkg::PIX_W-1:0]      pix_red,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [wcc_pkg::PIX_W-1:0]      out_blue,
  input  logic [wcc_pkg::PIX_W-1:0]      out_green,
  input  logic [wcc_pkg::PIX_W-1:0]      out_red,
  output int                             mismatches,
  output int                             in_flight
);

  typedef struct packed {
    logic [wcc_pkg::PIX_W-1:0] blue;
    logic [wcc_pkg::PIX_W-1:0] green;
    logic [wcc_pkg::PIX_W-1:0] red;
  } bgr_pixel_t;

  logic [wcc_pkg::SAMPLE_W-1:0]       white_blue;
  logic [wcc_pkg::SAMPLE_W-1:0]       white_green;
  logic [wcc_pkg::SAMPLE_W-1:0]       white_red;
  logic signed [wcc_pkg::SHIFT_W-1:0] cast_blue;
  logic signed [wcc_pkg::SHIFT_W-1:0] cast_green;
  logic signed [wcc_pkg::SHIFT_W-1:0] cast_red;

  bgr_pixel_t corrected_q[$];
  int         err_cnt = 0;

  initial begin
    mismatches = 0;
    in_flight  = 0;
  end

  function automatic logic [wcc_pkg::PIX_W-1:0] corrected_level(
    input logic [wcc_pkg::PIX_W-1:0]         level,
    input logic [wcc_pkg::SAMPLE_W-1:0]      white,
    input logic signed [wcc_pkg::SHIFT_W-1:0] cast
  );
    longint p, s, c, d, t, q;
    p = level;
    s = white;
    c = cast;
    // keep the divisor nonzero
    if (s < 1) s = 1;
    if (s > 254) s = 254;
    if (p < s) begin
      d = s;
      t = s - p;
    end else begin
      d = 255 - s;
      t = p - s;
    end
    q = (p * d - c * (d - t)) / d;
    if (q < 0) q = 0;
    if (q > 255) q = 255;
    return q[wcc_pkg::PIX_W-1:0];
  endfunction

  always @(posedge clk) begin : watch
    bgr_pixel_t want;
    bgr_pixel_t got;
    if (rst) begin
      white_blue  = wcc_pkg::SAMPLE_BLUE_RST;
      white_green = wcc_pkg::SAMPLE_GREEN_RST;
      white_red   = wcc_pkg::SAMPLE_RED_RST;
      cast_blue   = wcc_pkg::SHIFT_BLUE_RST;
      cast_green  = wcc_pkg::SHIFT_GREEN_RST;
      cast_red    = wcc_pkg::SHIFT_RED_RST;
      corrected_q.delete();
    end else begin
      if (in_valid && in_ready) begin
        want.blue  = corrected_level(pix_blue, white_blue, cast_blue);
        want.green = corrected_level(pix_green, white_green, cast_green);
        want.red   = corrected_level(pix_red, white_red, cast_red);
        corrected_q.push_back(want);
      end
      if (cfg_write) begin
        unique case (cfg_index)
          wcc_pkg::REG_SAMPLE_BLUE:  white_blue  = cfg_data[wcc_pkg::SAMPLE_W-1:0];
          wcc_pkg::REG_SAMPLE_GREEN: white_green = cfg_data[wcc_pkg::SAMPLE_W-1:0];
          wcc_pkg::REG_SAMPLE_RED:   white_red   = cfg_data[wcc_pkg::SAMPLE_W-1:0];
          wcc_pkg::REG_SHIFT_BLUE:   cast_blue   = cfg_data;
          wcc_pkg::REG_SHIFT_GREEN:  cast_green  = cfg_data;
          wcc_pkg::REG_SHIFT_RED:    cast_red    = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got.blue  = out_blue;
        got.green = out_green;
        got.red   = out_red;
        if (corrected_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("%0t: unexpected pixel b=%0d g=%0d r=%0d", $realtime,
                     got.blue, got.green, got.red);
        end else begin
          want = corrected_q.pop_front();
          if (got.blue != want.blue || got.green != want.green || got.red != want.red) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("%0t: pixel mismatch exp b=%0d g=%0d r=%0d got b=%0d g=%0d r=%0d",
                       $realtime, want.blue, want.green, want.red,
                       got.blue, got.green, got.red);
          end
        end
      end
    end
    mismatches <= err_cnt;
    in_flight  <= corrected_q.size();
  end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int PIX_W       = wcc_pkg::PIX_W;
  localparam int CFG_IDX_W   = wcc_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W  = wcc_pkg::CFG_DATA_W;
  localparam int STALL_LIMIT = 500;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_MOSTLY,
    RX_RARELY,
    RX_EVERY_THIRD
  } rx_mode_t;

  typedef struct {
    logic [CFG_DATA_W-1:0] sample_blue;
    logic [CFG_DATA_W-1:0] sample_green;
    logic [CFG_DATA_W-1:0] sample_red;
    logic [CFG_DATA_W-1:0] shift_blue;
    logic [CFG_DATA_W-1:0] shift_green;
    logic [CFG_DATA_W-1:0] shift_red;
  } wcc_setting_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  logic [PIX_W-1:0]      pix_blue  = '0;
  logic [PIX_W-1:0]      pix_green = '0;
  logic [PIX_W-1:0]      pix_red   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [PIX_W-1:0]      out_blue;
  logic [PIX_W-1:0]      out_green;
  logic [PIX_W-1:0]      out_red;

  int           mismatches;
  int           in_flight;
  int           burst_left = 0;
  int           idle_cycles = 0;
  wcc_setting_t setting;
  rx_mode_t     rx_mode = RX_ALWAYS;
  int           rx_left = 0;
  int           rx_phase = 0;

  always #2 clk = ~clk;

  weighted_color_correction i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .pix_blue  (pix_blue),
    .pix_green (pix_green),
    .pix_red   (pix_red),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_blue  (out_blue),
    .out_green (out_green),
    .out_red   (out_red)
  );

  wcc_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .pix_blue   (pix_blue),
    .pix_green  (pix_green),
    .pix_red    (pix_red),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_blue   (out_blue),
    .out_green  (out_green),
    .out_red    (out_red),
    .mismatches (mismatches),
    .in_flight  (in_flight)
  );

  // receiver: switch at random between stall patterns
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = $urandom_range(16, 80);
      end
      rx_left--;
      rx_phase++;
      case (rx_mode)
        RX_ALWAYS:      out_ready <= 1'b1;
        RX_MOSTLY:      out_ready <= ($urandom_range(0, 3) != 0);
        RX_RARELY:      out_ready <= ($urandom_range(0, 3) == 0);
        RX_EVERY_THIRD: out_ready <= (rx_phase % 3 == 0);
        default:        out_ready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_write || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_pixel(input logic [PIX_W-1:0] b, input logic [PIX_W-1:0] g,
                            input logic [PIX_W-1:0] r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid  <= 1'b1;
    pix_blue  <= b;
    pix_green <= g;
    pix_red   <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
  endtask

  // hold off the sender until every corrected pixel is out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic apply_setting();
    wait_drained();
    write_reg(wcc_pkg::REG_SAMPLE_BLUE, setting.sample_blue);
    write_reg(wcc_pkg::REG_SAMPLE_GREEN, setting.sample_green);
    write_reg(wcc_pkg::REG_SAMPLE_RED, setting.sample_red);
    write_reg(wcc_pkg::REG_SHIFT_BLUE, setting.shift_blue);
    write_reg(wcc_pkg::REG_SHIFT_GREEN, setting.shift_green);
    write_reg(wcc_pkg::REG_SHIFT_RED, setting.shift_red);
    // unmapped index, must be dropped
    write_reg(CFG_IDX_W'($urandom_range(wcc_pkg::REG_SHIFT_RED + 1, (1 << CFG_IDX_W) - 1)),
              CFG_DATA_W'($urandom));
    cfg_write <= 1'b0;
  endtask

  task automatic directed_sweep();
    logic [PIX_W-1:0] sb, sg, sr;
    sb = setting.sample_blue[PIX_W-1:0];
    sg = setting.sample_green[PIX_W-1:0];
    sr = setting.sample_red[PIX_W-1:0];
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(sb, sg, sr);
    send_pixel(sb - 8'd1, sg - 8'd1, sr - 8'd1);
    send_pixel(sb + 8'd1, sg + 8'd1, sr + 8'd1);
    send_pixel(8'd1, 8'd254, 8'd128);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return {1'($urandom), 8'h00};
      1: return {1'($urandom), 8'hFF};
      2: return {1'($urandom), ($urandom_range(0, 1) != 0) ? 8'd1 : 8'd254};
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_shift();
    case ($urandom_range(0, 5))
      0: return 9'h100;
      1: return 9'h0FF;
      2: return 9'h101;
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  // bias toward the white sample, where the weight peaks and its slope changes
  function automatic logic [PIX_W-1:0] pick_level(input logic [CFG_DATA_W-1:0] white);
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd255;
      2, 3, 4: return white[PIX_W-1:0] + PIX_W'($urandom_range(0, 8)) - 8'd4;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  initial begin
    setting.sample_blue  = CFG_DATA_W'(wcc_pkg::SAMPLE_BLUE_RST);
    setting.sample_green = CFG_DATA_W'(wcc_pkg::SAMPLE_GREEN_RST);
    setting.sample_red   = CFG_DATA_W'(wcc_pkg::SAMPLE_RED_RST);
    setting.shift_blue   = CFG_DATA_W'(wcc_pkg::SHIFT_BLUE_RST);
    setting.shift_green  = CFG_DATA_W'(wcc_pkg::SHIFT_GREEN_RST);
    setting.shift_red    = CFG_DATA_W'(wcc_pkg::SHIFT_RED_RST);
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_sweep();

    setting.sample_blue  = 9'd1;
    setting.sample_green = 9'd254;
    setting.sample_red   = 9'd0;
    setting.shift_blue   = 9'h0FF;
    setting.shift_green  = 9'h100;
    setting.shift_red    = 9'h101;
    apply_setting();
    directed_sweep();

    setting.sample_blue  = 9'd254;
    setting.sample_green = 9'd1;
    setting.sample_red   = 9'h1FF;
    setting.shift_blue   = 9'h101;
    setting.shift_green  = 9'h0FF;
    setting.shift_red    = 9'd0;
    apply_setting();
    directed_sweep();

    for (int phase = 0; phase < 8; phase++) begin
      setting.sample_blue  = pick_sample();
      setting.sample_green = pick_sample();
      setting.sample_red   = pick_sample();
      setting.shift_blue   = pick_shift();
      setting.shift_green  = pick_shift();
      setting.shift_red    = pick_shift();
      apply_setting();
      for (int n = 0; n < 66; n++) begin
        if ($urandom_range(0, 59) == 0) wait_drained();
        send_pixel(pick_level(setting.sample_blue), pick_level(setting.sample_green),
                   pick_level(setting.sample_red));
      end
    end

    wait_drained();
    repeat (wcc_pkg::NUM_STAGES + 8) @(posedge clk);
    if (mismatches == 0 && in_flight == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
